@@ hdl/sidlf_pkg.sv @@
// ----------------------------------------------------------------------------
// sidlf_pkg
// Codes, character constants and parser phase type for the subscription id
// list filter.
// ----------------------------------------------------------------------------
package sidlf_pkg;

  // input item kinds (in_tuser)
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // result kinds (out_tuser)
  localparam logic RES_ANSWER = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  // text characters
  localparam logic [7:0] CHAR_BAR   = 8'h7C;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_TILDE  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_BAD    = 2'd3
  } phase_t;

endpackage

@@ hdl/subscription_id_list_filter.sv @@
// ----------------------------------------------------------------------------
// subscription_id_list_filter
// Parses '|'-separated subscribe / '~'unsubscribe id tokens into a small
// id table and answers id queries against it, with wildcard id 0.
// ----------------------------------------------------------------------------
//  channel | dir | tuser            | tdata (low bit up)
//  in_     | in  | kind[1:0]        | text_byte[7:0], query_id[ID_BITS-1:0]
//  out_    | out | result_kind      | subscribed, entry_count, table_full
//
//  From input accept to result: input register, then one pass
//  through the table compare and parser into the result register.
//  One item per cycle sustained while results are taken; throughput is set by
//  the single-pass compare across all table entries.
//  A stalled result holds the result register; the input register still
//  drains items that give no result.
//  Reset (rst_n low, synchronous) empties the table and closes any text.
// ----------------------------------------------------------------------------
module subscription_id_list_filter #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ID_BITS       = 64,
  localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1),
  localparam int IN_DW        = ((8 + ID_BITS + 7) / 8) * 8,
  localparam int OUT_DW       = ((CNT_W + 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // text_byte, query_id
  input  logic [1:0]        in_tuser,   // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // subscribed, entry_count, table_full
  output logic              out_tuser   // result_kind
);

  localparam logic [ID_BITS-1:0] MAXV      = {ID_BITS{1'b1}};
  localparam logic [ID_BITS-1:0] MAX_DIV10 = MAXV / 10;
  localparam logic [3:0]         MAX_MOD10 = 4'(MAXV % 10);
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(TABLE_ENTRIES);

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  logic [1:0]         s1_kind_r;
  logic [7:0]         s1_byte_r;
  logic [ID_BITS-1:0] s1_qid_r;

  // table
  logic [ID_BITS-1:0]       ids_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] flags_r;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     dropped_r, dropped_nxt;

  // parser
  logic [ID_BITS-1:0]  tok_val_r, tok_val_nxt;
  sidlf_pkg::phase_t   phase_r, phase_nxt;
  logic                unsub_r, unsub_nxt;
  logic                text_open_r, text_open_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_sub_r, out_full_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic                     is_byte, is_end, is_query;
  logic                     gives_result, advance, clr;
  logic [TABLE_ENTRIES-1:0] valid_eff, id_eq, zero_eq, hit, wild, free_v, free_oh;
  logic [TABLE_ENTRIES-1:0] wr_new, wr_flag;
  logic [CNT_W-1:0]         count_eff;
  logic                     dropped_eff;
  logic [ID_BITS-1:0]       val_eff, cmp_id, val_x10;
  sidlf_pkg::phase_t        phase_eff;
  logic                     unsub_eff;
  logic                     is_bar, is_tilde, is_digit, ovf;
  logic [3:0]               digit;
  logic                     commit, any_match, any_free, ans;

  assign is_byte  = s1_kind_r == sidlf_pkg::KIND_BYTE;
  assign is_end   = s1_kind_r == sidlf_pkg::KIND_END;
  assign is_query = s1_kind_r == sidlf_pkg::KIND_QUERY;

  assign gives_result = is_end || is_query;
  assign advance      = s1_valid_r && (!gives_result || !out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || advance;

  // first byte or end mark of a new text clears table and token
  assign clr         = !text_open_r && (is_byte || is_end);
  assign valid_eff   = clr ? '0 : valid_r;
  assign count_eff   = clr ? '0 : count_r;
  assign dropped_eff = clr ? 1'b0 : dropped_r;
  assign val_eff     = clr ? '0 : tok_val_r;
  assign phase_eff   = clr ? sidlf_pkg::PH_START : phase_r;
  assign unsub_eff   = clr ? 1'b0 : unsub_r;

  assign is_bar   = s1_byte_r == sidlf_pkg::CHAR_BAR;
  assign is_tilde = s1_byte_r == sidlf_pkg::CHAR_TILDE;
  assign is_digit = (s1_byte_r >= sidlf_pkg::CHAR_ZERO) && (s1_byte_r <= sidlf_pkg::CHAR_NINE);
  assign digit    = 4'(s1_byte_r - sidlf_pkg::CHAR_ZERO);
  assign ovf      = (val_eff > MAX_DIV10) || ((val_eff == MAX_DIV10) && (digit > MAX_MOD10));
  assign val_x10  = (val_eff << 3) + (val_eff << 1) + {{(ID_BITS-4){1'b0}}, digit};

  // shared compare: query id or token value against every entry
  assign cmp_id = is_query ? s1_qid_r : val_eff;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      id_eq[i]   = ids_r[i] == cmp_id;
      zero_eq[i] = ids_r[i] == '0;
    end
  end

  assign hit      = valid_eff & id_eq;
  assign wild     = valid_eff & zero_eq;
  assign free_v   = ~valid_eff;
  assign free_oh  = free_v & (~free_v + 1'b1);
  assign any_match = |hit;
  assign any_free  = |free_v;
  assign ans      = any_match ? |(hit & flags_r) : |(wild & flags_r);

  assign commit = s1_valid_r && ((is_byte && is_bar) || is_end)
                  && (phase_eff == sidlf_pkg::PH_DIGITS);

  // token phase
  always_comb begin
    phase_nxt   = phase_r;
    tok_val_nxt = tok_val_r;
    unsub_nxt   = unsub_r;
    if (advance && (is_end || (is_byte && is_bar))) begin
      phase_nxt   = sidlf_pkg::PH_START;
      tok_val_nxt = '0;
      unsub_nxt   = 1'b0;
    end else if (advance && is_byte) begin
      phase_nxt   = phase_eff;
      tok_val_nxt = val_eff;
      unsub_nxt   = unsub_eff;
      if (phase_eff != sidlf_pkg::PH_BAD) begin
        if (is_tilde) begin
          if (phase_eff == sidlf_pkg::PH_START) begin
            phase_nxt = sidlf_pkg::PH_TILDE;
            unsub_nxt = 1'b1;
          end else begin
            phase_nxt = sidlf_pkg::PH_BAD;
          end
        end else if (is_digit && !ovf) begin
          phase_nxt   = sidlf_pkg::PH_DIGITS;
          tok_val_nxt = val_x10;
        end else begin
          phase_nxt = sidlf_pkg::PH_BAD;
        end
      end
    end
  end

  // table update
  always_comb begin
    valid_nxt   = valid_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    wr_new      = '0;
    wr_flag     = '0;
    if (advance && (is_byte || is_end)) begin
      valid_nxt   = valid_eff;
      count_nxt   = count_eff;
      dropped_nxt = dropped_eff;
      if (commit) begin
        if (any_match) begin
          wr_flag = hit;
        end else if (any_free) begin
          wr_new    = free_oh;
          wr_flag   = free_oh;
          valid_nxt = valid_eff | free_oh;
          count_nxt = count_eff + 1'b1;
        end else begin
          dropped_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    text_open_nxt = text_open_r;
    if (advance && is_byte) begin
      text_open_nxt = 1'b1;
    end else if (advance && is_end) begin
      text_open_nxt = 1'b0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && gives_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      tok_val_r   <= '0;
      phase_r     <= sidlf_pkg::PH_START;
      unsub_r     <= 1'b0;
      text_open_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      tok_val_r   <= tok_val_nxt;
      phase_r     <= phase_nxt;
      unsub_r     <= unsub_nxt;
      text_open_r <= text_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_qid_r  <= in_tdata[8 +: ID_BITS];
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (wr_new[i]) begin
        ids_r[i] <= val_eff;
      end
      if (wr_flag[i]) begin
        flags_r[i] <= !unsub_eff;
      end
    end
    if (advance && gives_result) begin
      out_kind_r <= is_end ? sidlf_pkg::RES_REPORT : sidlf_pkg::RES_ANSWER;
      out_sub_r  <= is_query && ans;
      out_cnt_r  <= is_end ? count_nxt : '0;
      out_full_r <= is_end && dropped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_DW-CNT_W-2){1'b0}}, out_full_r, out_cnt_r, out_sub_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above table size");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("entry count differs from valid entries");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> (count_r == CNT_FULL))
    else $error("drop flagged with free entries");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_end) |=> !text_open_r)
    else $error("text still open after end mark");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted item lost from input register");

endmodule
